FILE: hdl/name_directory_table_macros.svh
// ------------------------------------------------------------------------
// name_directory_table assertion macros
// shared property wrappers for the directory table checkers
// ------------------------------------------------------------------------
`ifndef NAME_DIRECTORY_TABLE_MACROS_SVH
`define NAME_DIRECTORY_TABLE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define NDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off while in reset
`define NDT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/ndt_pkg.sv
// ------------------------------------------------------------------------
// ndt_pkg
// types, codes and helpers shared by the name directory table
// ------------------------------------------------------------------------
package ndt_pkg;

    // default table depth
    localparam int unsigned ENTRIES_DEF = 32;

    // field widths of the stream payloads
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned NAME_W   = 160;
    localparam int unsigned OUT_W    = 168;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LIST   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_CREATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EXISTS   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd7;

    // one 20-byte name, byte 0 in the lowest bits
    typedef struct packed {
        logic [31:0] high;
        logic [63:0] mid;
        logic [63:0] low;
    } t_name;

    // what enters the tail cell of the ring
    typedef enum logic [1:0] {
        TAIL_HEAD,
        TAIL_NEXT,
        TAIL_KEY
    } t_tail_sel;

    // ring control from the sequencer
    typedef struct packed {
        logic      shift;
        t_tail_sel sel;
    } t_ring_ctl;

    // zero every byte after the first zero byte
    function automatic t_name canon_name(input t_name n);
        logic [NAME_W-1:0] v;
        logic [NAME_W-1:0] r;
        logic [19:0]       z;
        logic [19:0]       below;
        v = n;
        for (int b = 0; b < 20; b++) begin
            z[b] = (v[8*b +: 8] == 8'h00);
        end
        for (int b = 0; b < 20; b++) begin
            below = (20'(1) << b) - 20'(1);
            r[8*b +: 8] = ((z & below) == 20'h0) ? v[8*b +: 8] : 8'h00;
        end
        return t_name'(r);
    endfunction

endpackage

FILE: hdl/ndt_cell.sv
// ------------------------------------------------------------------------
// ndt_cell
// one table slot; passes its name to the neighbor on every shift
// ------------------------------------------------------------------------
module ndt_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  ndt_pkg::t_name i_d,
    output ndt_pkg::t_name o_q
);
    import ndt_pkg::*;

    t_name r_q;

    // slot storage, payload only
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

FILE: hdl/ndt_ring.sv
// ------------------------------------------------------------------------
// ndt_ring
// row of slot cells closed into a ring; the head wraps to the tail
// ------------------------------------------------------------------------
module ndt_ring #(
    parameter int unsigned N = ndt_pkg::ENTRIES_DEF
) (
    input  logic              i_clk,
    input  ndt_pkg::t_ring_ctl i_ctl,
    input  ndt_pkg::t_name     i_key,
    output ndt_pkg::t_name     o_head
);
    import ndt_pkg::*;

    t_name q[N];
    t_name next_q;
    t_name tail_d;

    // entry behind the head, used to close a gap on delete
    generate
        if (N > 1) begin : g_next
            assign next_q = q[1];
        end else begin : g_next_one
            assign next_q = q[0];
        end
    endgenerate

    // tail input select
    always_comb begin
        case (i_ctl.sel)
            TAIL_NEXT: tail_d = next_q;
            TAIL_KEY:  tail_d = i_key;
            default:   tail_d = q[0];
        endcase
    end

    // the cell chain
    generate
        for (genvar i = 0; i < N; i++) begin : g_cell
            t_name d;
            if (i == N - 1) begin : g_tail
                assign d = tail_d;
            end else begin : g_mid
                assign d = q[i+1];
            end
            ndt_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctl.shift),
                .i_d     (d),
                .o_q     (q[i])
            );
        end
    endgenerate

    assign o_head = q[0];

endmodule

FILE: hdl/name_directory_table.sv
// ------------------------------------------------------------------------
// name_directory_table
// compacted table of up to ENTRIES names with create, delete, search, list
// ------------------------------------------------------------------------
// Requests enter on the slave stream: tuser carries the kind (create,
// delete, search, list), tdata the 20-byte name. Results leave on the
// master stream: tuser is the status, tdata the position and listed name,
// tlast marks the final result of a request.
// The names sit in a ring of ENTRIES cells. Every request walks the ring
// once, one slot per cycle while no listed result is stalled, comparing
// the slot at the head with the key; create drops the key into the first
// free slot and delete closes the gap while the ring turns, so the order
// is back in place after the walk.
// A single-result request has its result on the master stream after one
// walk of the ring and the reply state, and the next request is taken
// after the reply state even while the result waits in the output register.
// A list emits one result per stored entry during the walk (one empty
// result for an empty table) and is ready for the next request after the
// walk; a stalled receiver holds the ring and delays the reply state.
// Reset empties the table (entry count zero) and drops any pending result.
// ------------------------------------------------------------------------
module name_directory_table #(
    parameter int unsigned ENTRIES = ndt_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [ndt_pkg::NAME_W-1:0]    i_s_tdata,  // key_word_low, key_word_mid, key_word_high
    input  logic [ndt_pkg::KIND_W-1:0]    i_s_tuser,  // kind
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [ndt_pkg::OUT_W-1:0]     o_m_tdata,  // position, entry_word_low, entry_word_mid,
                                                      // entry_word_high, zero pad
    output logic [ndt_pkg::STATUS_W-1:0]  o_m_tuser,  // status
    output logic                          o_m_tlast   // last
);
    import ndt_pkg::*;

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_REPLY
    } t_state;

    t_state                r_state, n_state;
    logic [KIND_W-1:0]     r_kind, n_kind;
    t_name                 r_key, n_key;
    logic [IW-1:0]         r_step, n_step;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_hit, n_hit;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [POS_W-1:0]      r_out_pos, n_out_pos;
    t_name                 r_out_name, n_out_name;
    logic                  r_out_last, n_out_last;

    t_name     head;
    t_ring_ctl ring_ctl;
    logic      out_free;
    logic      in_range;
    logic      hit_now;
    logic      last_step;
    logic      advance;
    logic      is_list;

    ndt_ring #(
        .N (ENTRIES)
    ) u_ring (
        .i_clk  (i_clk),
        .i_ctl  (ring_ctl),
        .i_key  (r_key),
        .o_head (head)
    );

    // walk step decode
    assign out_free  = !r_out_valid || i_m_tready;
    assign in_range  = (CW'(r_step) < r_count);
    assign hit_now   = in_range && !r_hit && (head == r_key);
    assign last_step = (r_step == IW'(ENTRIES - 1));
    assign is_list   = (r_kind == KIND_LIST);
    assign advance   = !is_list || !in_range || out_free;

    // ring control
    always_comb begin
        ring_ctl.shift = (r_state == S_WALK) && advance;
        ring_ctl.sel   = TAIL_HEAD;
        if ((r_kind == KIND_DELETE) && (r_hit || hit_now)) begin
            ring_ctl.sel = TAIL_NEXT;
        end else if ((r_kind == KIND_CREATE) && (CW'(r_step) == r_count)) begin
            ring_ctl.sel = TAIL_KEY;
        end
    end

    // sequencer and result register, next values
    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_key        = r_key;
        n_step       = r_step;
        n_count      = r_count;
        n_hit        = r_hit;
        n_pos        = r_pos;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_name   = r_out_name;
        n_out_last   = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_kind  = i_s_tuser;
                    n_key   = canon_name(t_name'(i_s_tdata));
                    n_step  = '0;
                    n_hit   = 1'b0;
                    n_pos   = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (advance) begin
                    if (hit_now) begin
                        n_hit = 1'b1;
                        n_pos = POS_W'(r_step) + POS_W'(1);
                    end
                    // one listed entry per occupied step
                    if (is_list && in_range) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_LISTED;
                        n_out_pos    = POS_W'(r_step) + POS_W'(1);
                        n_out_name   = head;
                        n_out_last   = ((CW'(r_step) + CW'(1)) == r_count);
                    end
                    if (last_step) begin
                        n_step  = '0;
                        n_state = (is_list && (r_count != '0)) ? S_IDLE : S_REPLY;
                    end else begin
                        n_step = r_step + IW'(1);
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = '0;
                    n_out_name  = '0;
                    n_out_last  = 1'b1;
                    case (r_kind)
                        KIND_CREATE: begin
                            if (r_hit) begin
                                n_out_status = ST_EXISTS;
                            end else if (r_count == CW'(ENTRIES)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_status = ST_CREATED;
                                n_count      = r_count + CW'(1);
                            end
                        end
                        KIND_DELETE: begin
                            if (r_hit) begin
                                n_out_status = ST_DELETED;
                                n_count      = r_count - CW'(1);
                            end else begin
                                n_out_status = ST_NOTFOUND;
                            end
                        end
                        KIND_SEARCH: begin
                            n_out_status = r_hit ? ST_FOUND : ST_NOTFOUND;
                            n_out_pos    = r_hit ? r_pos : '0;
                        end
                        default: begin
                            n_out_status = ST_EMPTY;
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_hit       <= n_hit;
            r_step      <= n_step;
        end
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_pos        <= n_pos;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_name   <= n_out_name;
        r_out_last   <= n_out_last;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_name, r_out_pos};
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;

endmodule

FILE: hdl/ndt_checker.sv
// ------------------------------------------------------------------------
// ndt_checker
// port-level checks on the name directory table, bound to the top level
// ------------------------------------------------------------------------
`include "name_directory_table_macros.svh"

module ndt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [ndt_pkg::OUT_W-1:0]     o_m_tdata,  // position, entry words, zero pad
    input logic [ndt_pkg::STATUS_W-1:0]  o_m_tuser,  // status
    input logic                          o_m_tlast   // last
);
    import ndt_pkg::*;

    logic req_accept;
    logic listed;

    assign req_accept = i_s_tvalid && o_s_tready;
    assign listed     = o_m_tvalid && (o_m_tuser == ST_LISTED);

    // a request occupies the block for its whole walk
    `NDT_ASSERT_NXT(a_busy_after_accept, req_accept, !o_s_tready,
        "request taken while the ring walk was still running")

    // a listed entry always carries a position
    `NDT_ASSERT_NOW(a_listed_pos, listed, o_m_tdata[POS_W-1:0] != '0,
        "listed result with a zero position")

    // every single-result request ends with last set
    `NDT_ASSERT_NOW(a_single_last, o_m_tvalid && !listed, o_m_tlast,
        "status result without last")

    // a stalled result holds
    `NDT_ASSERT_NXT(a_stall_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser),
        "result changed while stalled")

endmodule

bind name_directory_table ndt_checker u_ndt_checker (.*);

FILE: dv/tb_name_directory_table.sv
// ------------------------------------------------------------------------
// tb_name_directory_table
// self-checking bench for the name directory table
// ------------------------------------------------------------------------
// Drives create, delete, search and list requests on the request stream and
// checks every result against a behavioral copy of the table kept in the
// bench. Directed tests cover the empty table, names from empty to full
// length, bytes after the terminator, shifting on delete and a full table;
// random traffic over a small name pool then mixes all four kinds under
// random idling on both streams, ending with a stretch of back-to-back traffic.
// ------------------------------------------------------------------------
module tb_name_directory_table;
    import ndt_pkg::*;

    localparam int unsigned TABLE_DEPTH  = ENTRIES_DEF;
    localparam int          RANDOM_ITEMS = 140;
    localparam int          POOL_SIZE    = 40;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          PRINT_LIMIT  = 40;

    // one expected result on the result stream
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        t_name               name;
        logic                last;
    } t_dir_reply;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [NAME_W-1:0]   s_tdata  = '0;
    logic [KIND_W-1:0]   s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                m_tlast;

    // bench copy of the directory
    t_name      dir_names [TABLE_DEPTH];
    int         dir_count = 0;
    t_dir_reply awaited_replies [$];

    bit idle_on      = 1'b1;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int fail_count   = 0;

    // run statistics
    int kind_counts [4] = '{0, 0, 0, 0};
    int replies_checked = 0;
    int peak_count      = 0;
    int full_rejects    = 0;
    int empty_lists     = 0;

    name_directory_table #(
        .ENTRIES    (TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),  // key_word_low, key_word_mid, key_word_high
        .i_s_tuser  (s_tuser),  // kind
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),  // position, entry_word_low, entry_word_mid,
                                // entry_word_high, zero pad
        .o_m_tuser  (m_tuser),  // status
        .o_m_tlast  (m_tlast)   // last
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mismatch reporting
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    // clear every byte after the first zero byte
    function automatic t_name canonical_key(input t_name raw);
        logic [NAME_W-1:0] v;
        bit                ended;
        v     = raw;
        ended = 1'b0;
        for (int b = 0; b < 20; b++) begin
            if (ended) begin
                v[8*b +: 8] = 8'h00;
            end else if (v[8*b +: 8] == 8'h00) begin
                ended = 1'b1;
            end
        end
        return t_name'(v);
    endfunction

    // apply one request to the bench table and queue the results it gives
    function automatic void apply_directory_request(input logic [KIND_W-1:0] kind,
                                                    input t_name raw);
        t_name      key;
        int         hit;
        t_dir_reply r;
        key  = canonical_key(raw);
        hit  = -1;
        r    = '0;
        r.last = 1'b1;
        for (int i = 0; i < dir_count; i++) begin
            if (hit < 0 && dir_names[i] == key) hit = i;
        end
        case (kind)
            KIND_CREATE: begin
                if (hit >= 0) begin
                    r.status = ST_EXISTS;
                end else if (dir_count >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                    full_rejects++;
                end else begin
                    dir_names[dir_count] = key;
                    dir_count++;
                    if (dir_count > peak_count) peak_count = dir_count;
                    r.status = ST_CREATED;
                end
                awaited_replies.push_back(r);
            end
            KIND_DELETE: begin
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    for (int i = hit; i + 1 < dir_count; i++) begin
                        dir_names[i] = dir_names[i + 1];
                    end
                    dir_count--;
                    r.status = ST_DELETED;
                end
                awaited_replies.push_back(r);
            end
            KIND_SEARCH: begin
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.status   = ST_FOUND;
                    r.position = POS_W'(hit + 1);
                end
                awaited_replies.push_back(r);
            end
            KIND_LIST: begin
                if (dir_count == 0) begin
                    r.status = ST_EMPTY;
                    empty_lists++;
                    awaited_replies.push_back(r);
                end
                for (int i = 0; i < dir_count; i++) begin
                    r.status   = ST_LISTED;
                    r.position = POS_W'(i + 1);
                    r.name     = dir_names[i];
                    r.last     = (i + 1 == dir_count);
                    awaited_replies.push_back(r);
                end
            end
        endcase
    endfunction

    // send one request, with an optional idle burst ahead of it
    task automatic send_request(input logic [KIND_W-1:0] kind, input t_name key);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= kind;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        apply_directory_request(kind, key);
        kind_counts[kind]++;
    endtask

    // hold the request stream until every expected result has arrived
    task automatic hold_until_replies_done();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (awaited_replies.size() != 0);
        @(posedge i_clk);
    endtask

    // name of len nonzero bytes, zero after
    function automatic t_name random_name(input int len);
        logic [NAME_W-1:0] v;
        v = '0;
        for (int b = 0; b < len; b++) v[8*b +: 8] = 8'($urandom_range(1, 255));
        return t_name'(v);
    endfunction

    // random bytes after the terminator, the terminator itself kept
    function automatic t_name add_trailing_junk(input t_name n);
        logic [NAME_W-1:0] v;
        int                len;
        v   = n;
        len = 20;
        for (int b = 19; b >= 0; b--) begin
            if (v[8*b +: 8] == 8'h00) len = b;
        end
        for (int b = len + 1; b < 20; b++) v[8*b +: 8] = 8'($urandom());
        return t_name'(v);
    endfunction

    function automatic t_name noise_name();
        return t_name'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    endfunction

    // result checking
    always @(posedge i_clk) begin : reply_checker
        t_dir_reply want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch($sformatf("result with none expected, status %0d", m_tuser));
            end else begin
                want = awaited_replies.pop_front();
                replies_checked++;
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
                if (m_tdata[POS_W-1:0] !== want.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              m_tdata[POS_W-1:0], want.position));
                if (m_tdata[POS_W +: 64] !== want.name.low)
                    report_mismatch($sformatf("entry_word_low %h, expected %h",
                                              m_tdata[POS_W +: 64], want.name.low));
                if (m_tdata[POS_W+64 +: 64] !== want.name.mid)
                    report_mismatch($sformatf("entry_word_mid %h, expected %h",
                                              m_tdata[POS_W+64 +: 64], want.name.mid));
                if (m_tdata[POS_W+128 +: 32] !== want.name.high)
                    report_mismatch($sformatf("entry_word_high %h, expected %h",
                                              m_tdata[POS_W+128 +: 32], want.name.high));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
            end
        end
    end

    // receiver stalls in bursts of random length
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // cycles since the last request or result moved
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    // watchdog
    initial begin
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("tb_name_directory_table NOT OK");
        $finish;
    end

    // lookups and listing on an empty table
    task automatic test_empty_table();
        send_request(KIND_SEARCH, random_name(5));
        send_request(KIND_DELETE, random_name(20));
        send_request(KIND_LIST, noise_name());
    endtask

    // names from empty to full length, junk after terminators, shifting on delete
    task automatic test_basic_operations();
        t_name empty_nm;
        t_name all_ones;
        t_name all_low;
        t_name long19;
        t_name abc;
        empty_nm = '0;
        all_ones = '1;
        all_low  = t_name'({20{8'h01}});
        long19   = random_name(19);
        abc      = t_name'(160'h636261);
        send_request(KIND_CREATE, add_trailing_junk(empty_nm));
        send_request(KIND_CREATE, all_ones);
        send_request(KIND_CREATE, all_low);
        send_request(KIND_CREATE, long19);
        send_request(KIND_CREATE, add_trailing_junk(abc));
        // same name, different trailing bytes
        send_request(KIND_CREATE, add_trailing_junk(abc));
        send_request(KIND_SEARCH, abc);
        send_request(KIND_SEARCH, add_trailing_junk(empty_nm));
        send_request(KIND_LIST, noise_name());
        send_request(KIND_DELETE, all_ones);
        send_request(KIND_LIST, noise_name());
        send_request(KIND_DELETE, add_trailing_junk(abc));
        send_request(KIND_DELETE, abc);
        send_request(KIND_DELETE, empty_nm);
        send_request(KIND_SEARCH, long19);
        send_request(KIND_LIST, '1);
    endtask

    // fill to capacity, reject on full, duplicate on full, reuse a slot
    task automatic test_full_table();
        t_name fresh;
        t_name spare;
        while (dir_count > 0) send_request(KIND_DELETE, add_trailing_junk(dir_names[dir_count-1]));
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            fresh = random_name($urandom_range(1, 20));
            fresh.low[7:0] = 8'h80 + 8'(i);
            send_request(KIND_CREATE, fresh);
        end
        spare = random_name(20);
        spare.low[7:0] = 8'h20;
        send_request(KIND_CREATE, spare);
        send_request(KIND_CREATE, add_trailing_junk(dir_names[TABLE_DEPTH/2]));
        send_request(KIND_SEARCH, dir_names[TABLE_DEPTH-1]);
        send_request(KIND_LIST, noise_name());
        send_request(KIND_DELETE, dir_names[0]);
        send_request(KIND_CREATE, spare);
        send_request(KIND_SEARCH, spare);
        send_request(KIND_LIST, noise_name());
    endtask

    // random mix over a small pool so that names collide
    task automatic test_random_traffic();
        t_name            pool [POOL_SIZE];
        t_name            key;
        int               pick;
        int               len;
        logic [KIND_W-1:0] kind;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) len = 0;
            else if (pick < 25) len = 20;
            else len = $urandom_range(1, 19);
            pool[i] = random_name(len);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - 30) idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 40) kind = KIND_CREATE;
            else if (pick < 65) kind = KIND_DELETE;
            else if (pick < 90) kind = KIND_SEARCH;
            else kind = KIND_LIST;
            if ($urandom_range(0, 9) == 0) key = noise_name();
            else key = pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 1) == 1) key = add_trailing_junk(key);
            send_request(kind, key);
            if (n == RANDOM_ITEMS / 2) hold_until_replies_done();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_basic_operations();
        test_full_table();
        test_random_traffic();

        // drain and let the last walk finish
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (awaited_replies.size() != 0);
        repeat (2 * TABLE_DEPTH + 8) @(posedge i_clk);
        if (awaited_replies.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_replies.size()));

        $display("covered %0d creates, %0d deletes, %0d searches, %0d lists; %0d results checked",
                 kind_counts[KIND_CREATE], kind_counts[KIND_DELETE],
                 kind_counts[KIND_SEARCH], kind_counts[KIND_LIST], replies_checked);
        $display("table peaked at %0d of %0d, %0d creates rejected as full, %0d empty lists",
                 peak_count, TABLE_DEPTH, full_rejects, empty_lists);
        if (fail_count == 0) begin
            $display("tb_name_directory_table OK");
        end else begin
            $display("tb_name_directory_table NOT OK");
        end
        $finish;
    end

endmodule
